// ===== hw/rtl/dmp_pkg.sv =====
// Shared types and constants for the DNS message parser.
// Beat structs, field kind codes, status codes and register map.
// No dependencies.
package dmp_pkg;

  localparam int unsigned MAX_NAME_LEN = 255;

  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_NAME_LIMIT = 1'b0;
  localparam logic [7:0] NAME_LIMIT_RESET = 8'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } msg_beat_t;

  typedef struct packed {
    logic [4:0]  field_kind;
    logic [1:0]  section;
    logic [31:0] field_value;
    logic [1:0]  status;
    logic        end_of_message;
  } res_beat_t;

  localparam logic [4:0] KIND_ID         = 5'd0;
  localparam logic [4:0] KIND_FLAGS1     = 5'd1;
  localparam logic [4:0] KIND_FLAGS2     = 5'd2;
  localparam logic [4:0] KIND_QDCOUNT    = 5'd3;
  localparam logic [4:0] KIND_NAME_BYTE  = 5'd7;
  localparam logic [4:0] KIND_NAME_END   = 5'd8;
  localparam logic [4:0] KIND_QTYPE      = 5'd9;
  localparam logic [4:0] KIND_QCLASS     = 5'd10;
  localparam logic [4:0] KIND_TYPE       = 5'd11;
  localparam logic [4:0] KIND_CLASS      = 5'd12;
  localparam logic [4:0] KIND_TTL        = 5'd13;
  localparam logic [4:0] KIND_RDLENGTH   = 5'd14;
  localparam logic [4:0] KIND_RDATA_BYTE = 5'd15;
  localparam logic [4:0] KIND_END_ONLY   = 5'd16;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_NAME_LONG = 2'd2;
  localparam logic [1:0] STATUS_TRUNC     = 2'd3;

endpackage

// ===== hw/rtl/dns_message_parser.sv =====
// Top level of the DNS message parser: input register, parse core, result register.
// Depends on dmp_pkg, dmp_apb_regs, dmp_in_reg, dmp_parse_core, dmp_out_reg.
//
//  port group  | handshake              | payload
//  msg         | msg_valid / msg_ready  | msg_beat_t (data_byte, last_byte)
//  res         | res_valid / res_ready  | res_beat_t (kind, section, value, status, end)
//  apb         | psel, penable, pready  | paddr, pwdata, prdata (name_limit at 0x0)
//
// One byte per cycle while results are not stalled; a byte is held in the input
// register, and any result it yields goes to the result register. The parse state
// updates once per byte, between the two registers. Reset clears all parse state
// and sets name_limit to 255. A stalled result holds the result register; the
// input register then fills and msg_ready drops.
module dns_message_parser
  import dmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_ready,
  input  msg_beat_t             msg,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_beat_t             res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic      q_valid;
  msg_beat_t q;
  logic      out_free;
  logic      advance;
  logic      res_have;
  res_beat_t res_d;
  logic [7:0] name_limit;

  assign advance = q_valid && out_free;

  dmp_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .name_limit (name_limit)
  );

  dmp_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .take      (advance),
    .q_valid   (q_valid),
    .q         (q)
  );

  dmp_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .beat       (q),
    .name_limit (name_limit),
    .res_have   (res_have),
    .res_beat   (res_d)
  );

  dmp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_have),
    .d         (res_d),
    .free      (out_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ===== hw/rtl/dmp_apb_regs.sv =====
// APB configuration register block for the DNS message parser.
// Holds name_limit; depends on dmp_pkg.
module dmp_apb_regs
  import dmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [7:0]            name_limit
);

  logic wr_en;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_NAME_LIMIT);
  assign wr_en  = psel && penable && pwrite && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= NAME_LIMIT_RESET;
    end else if (wr_en) begin
      name_limit <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit && (paddr[1:0] == 2'b00)) begin
      prdata = {24'd0, name_limit};
    end
  end

endmodule

// ===== hw/rtl/dmp_in_reg.sv =====
// Input register stage for message beats.
// Depends on dmp_pkg for the beat type.
module dmp_in_reg
  import dmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_ready,
  input  msg_beat_t msg,
  input  logic      take,
  output logic      q_valid,
  output msg_beat_t q
);

  assign msg_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (msg_ready) begin
      q_valid <= msg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_ready && msg_valid) begin
      q <= msg;
    end
  end

endmodule

// ===== hw/rtl/dmp_parse_core.sv =====
// Parse state and next-state logic for one message byte.
// Depends on dmp_pkg for beat types, kind and status codes.
module dmp_parse_core
  import dmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  msg_beat_t beat,
  input  logic [7:0] name_limit,
  output logic      res_have,
  output res_beat_t res_beat
);

  typedef enum logic [10:0] {
    PH_HDR    = 11'b00000000001,
    PH_NAME   = 11'b00000000010,
    PH_QTYPE  = 11'b00000000100,
    PH_QCLASS = 11'b00000001000,
    PH_TYPE   = 11'b00000010000,
    PH_CLASS  = 11'b00000100000,
    PH_TTL    = 11'b00001000000,
    PH_RDLEN  = 11'b00010000000,
    PH_RDATA  = 11'b00100000000,
    PH_DONE   = 11'b01000000000,
    PH_STOP   = 11'b10000000000
  } phase_t;

  phase_t           phase, phase_next;
  logic [3:0]       byte_in_field, byte_in_field_next;
  logic [31:0]      field_accum, field_accum_next;
  logic [3:0][15:0] section_counts, section_counts_next;
  logic [1:0]       current_section, current_section_next;
  logic [15:0]      records_left, records_left_next;
  logic [7:0]       name_length, name_length_next;
  logic [15:0]      rdata_left, rdata_left_next;
  logic [1:0]       sticky_status, sticky_status_next;

  function automatic logic [2:0] find_section(input logic [3:0][15:0] cnt,
                                              input logic [2:0] start);
    logic       found;
    logic [1:0] sel;
    found = 1'b0;
    sel   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (!found && (3'(i) >= start) && (cnt[i] != 16'd0)) begin
        found = 1'b1;
        sel   = 2'(i);
      end
    end
    return {found, sel};
  endfunction

  logic [7:0]  b;
  logic [31:0] acc_shift;
  logic [3:0]  bif_inc;
  logic [3:0]  fld_width;
  logic [8:0]  pos;
  logic [7:0]  lim;
  logic [1:0]  cnt_sel;
  logic        do_finish;
  logic        do_enter;
  logic [2:0]  enter_start;
  logic [2:0]  found_sel;
  logic [15:0] rl_dec;
  logic        have;
  logic [4:0]  kind;
  logic [31:0] val;
  logic [1:0]  sect;

  always_comb begin
    b         = beat.data_byte;
    acc_shift = {field_accum[23:0], b};
    bif_inc   = byte_in_field + 4'd1;
    fld_width = (phase == PH_TTL) ? 4'd4 : 4'd2;
    pos       = {1'b0, name_length} + 9'd1;
    lim       = (name_limit > 8'(MAX_NAME_LEN)) ? 8'(MAX_NAME_LEN) : name_limit;
    cnt_sel   = byte_in_field[2:1] + 2'd2;
    rl_dec    = records_left - 16'd1;

    phase_next           = phase;
    byte_in_field_next   = byte_in_field;
    field_accum_next     = field_accum;
    section_counts_next  = section_counts;
    current_section_next = current_section;
    records_left_next    = records_left;
    name_length_next     = name_length;
    rdata_left_next      = rdata_left;
    sticky_status_next   = sticky_status;

    do_finish   = 1'b0;
    do_enter    = 1'b0;
    enter_start = 3'd0;
    found_sel   = 3'd0;
    have        = 1'b0;
    kind        = KIND_END_ONLY;
    val         = 32'd0;
    sect        = current_section;

    case (phase)
      PH_HDR: begin
        field_accum_next   = acc_shift;
        byte_in_field_next = bif_inc;
        sect               = 2'd0;
        case (byte_in_field)
          4'd1: begin
            have = 1'b1;
            kind = KIND_ID;
            val  = {16'd0, acc_shift[15:0]};
          end
          4'd2: begin
            have = 1'b1;
            kind = KIND_FLAGS1;
            val  = {24'd0, b};
          end
          4'd3: begin
            have = 1'b1;
            kind = KIND_FLAGS2;
            val  = {24'd0, b};
          end
          4'd5, 4'd7, 4'd9, 4'd11: begin
            have = 1'b1;
            kind = KIND_QDCOUNT + {3'd0, cnt_sel};
            val  = {16'd0, acc_shift[15:0]};
            section_counts_next[cnt_sel] = acc_shift[15:0];
            if (byte_in_field == 4'd11) begin
              byte_in_field_next   = 4'd0;
              field_accum_next     = 32'd0;
              current_section_next = 2'd0;
              do_enter             = 1'b1;
              enter_start          = 3'd0;
            end
          end
          default: begin
          end
        endcase
      end
      PH_NAME: begin
        if (pos > {1'b0, lim}) begin
          sticky_status_next = STATUS_NAME_LONG;
          phase_next         = PH_STOP;
        end else if (b == 8'd0) begin
          have             = 1'b1;
          kind             = KIND_NAME_END;
          val              = {23'd0, pos};
          name_length_next = 8'd0;
          phase_next       = (current_section == 2'd0) ? PH_QTYPE : PH_TYPE;
        end else begin
          have             = 1'b1;
          kind             = KIND_NAME_BYTE;
          val              = {24'd0, b};
          name_length_next = pos[7:0];
        end
      end
      PH_QTYPE, PH_QCLASS, PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN: begin
        field_accum_next   = acc_shift;
        byte_in_field_next = bif_inc;
        if (bif_inc >= fld_width) begin
          have               = 1'b1;
          val                = acc_shift;
          byte_in_field_next = 4'd0;
          field_accum_next   = 32'd0;
          case (phase)
            PH_QTYPE: begin
              kind       = KIND_QTYPE;
              phase_next = PH_QCLASS;
            end
            PH_QCLASS: begin
              kind      = KIND_QCLASS;
              do_finish = 1'b1;
            end
            PH_TYPE: begin
              kind       = KIND_TYPE;
              phase_next = PH_CLASS;
            end
            PH_CLASS: begin
              kind       = KIND_CLASS;
              phase_next = PH_TTL;
            end
            PH_TTL: begin
              kind       = KIND_TTL;
              phase_next = PH_RDLEN;
            end
            default: begin
              kind            = KIND_RDLENGTH;
              rdata_left_next = acc_shift[15:0];
              if (acc_shift[15:0] == 16'd0) begin
                do_finish = 1'b1;
              end else begin
                phase_next = PH_RDATA;
              end
            end
          endcase
        end
      end
      PH_RDATA: begin
        have            = 1'b1;
        kind            = KIND_RDATA_BYTE;
        val             = {24'd0, b};
        rdata_left_next = rdata_left - 16'd1;
        if (rdata_left == 16'd1) begin
          do_finish = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_finish) begin
      records_left_next = rl_dec;
      if (rl_dec == 16'd0) begin
        do_enter    = 1'b1;
        enter_start = {1'b0, current_section} + 3'd1;
      end else begin
        name_length_next = 8'd0;
        phase_next       = PH_NAME;
      end
    end

    if (do_enter) begin
      found_sel = find_section(section_counts_next, enter_start);
      if (found_sel[2]) begin
        current_section_next = found_sel[1:0];
        records_left_next    = section_counts_next[found_sel[1:0]];
        name_length_next     = 8'd0;
        phase_next           = PH_NAME;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (beat.last_byte) begin
      if ((phase_next != PH_DONE) && (sticky_status_next == STATUS_OK)) begin
        sticky_status_next = (phase_next == PH_HDR) ? STATUS_SHORT : STATUS_TRUNC;
      end
      if (!have) begin
        kind = KIND_END_ONLY;
        val  = 32'd0;
      end
    end

    res_have                = have || beat.last_byte;
    res_beat.field_kind     = kind;
    res_beat.section        = sect;
    res_beat.field_value    = val;
    res_beat.status         = sticky_status_next;
    res_beat.end_of_message = beat.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && beat.last_byte)) begin
      phase           <= PH_HDR;
      byte_in_field   <= '0;
      field_accum     <= '0;
      section_counts  <= '0;
      current_section <= '0;
      records_left    <= '0;
      name_length     <= '0;
      rdata_left      <= '0;
      sticky_status   <= STATUS_OK;
    end else if (advance) begin
      phase           <= phase_next;
      byte_in_field   <= byte_in_field_next;
      field_accum     <= field_accum_next;
      section_counts  <= section_counts_next;
      current_section <= current_section_next;
      records_left    <= records_left_next;
      name_length     <= name_length_next;
      rdata_left      <= rdata_left_next;
      sticky_status   <= sticky_status_next;
    end
  end

endmodule

// ===== hw/rtl/dmp_out_reg.sv =====
// Result register for parsed field beats.
// Depends on dmp_pkg for the result beat type.
module dmp_out_reg
  import dmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  res_beat_t d,
  output logic      free,
  output logic      res_valid,
  input  logic      res_ready,
  output res_beat_t res
);

  assign free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res <= d;
    end
  end

endmodule

// ===== hw/rtl/dmp_checker.sv =====
// Port-level checks on the result channel of the DNS message parser.
// Depends on dmp_pkg; bound to dns_message_parser below.
module dmp_checker
  import dmp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input res_beat_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat dropped or changed while stalled");

  a_end_only_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.field_kind == KIND_END_ONLY) |-> res.end_of_message)
    else $error("end-only beat without end mark");

  a_short_trunc_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && ((res.status == STATUS_SHORT) || (res.status == STATUS_TRUNC))
    |-> res.end_of_message)
    else $error("short or truncated status before the last beat");

  a_header_section: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.field_kind < KIND_NAME_BYTE) |-> (res.section == 2'd0))
    else $error("header field outside section zero");

  a_name_end_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.field_kind == KIND_NAME_END)
    |-> (res.field_value[31:8] == 24'd0) && (res.field_value != 32'd0))
    else $error("name length out of range");

endmodule

bind dns_message_parser dmp_checker u_dmp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// ===== verif/tb_dns_message_parser.sv =====
// Testbench for dns_message_parser: drives DNS messages byte by byte, predicts each
// result beat in a local model of the parser, and compares the beats field by field.
// Depends on dmp_pkg and the dns_message_parser RTL.
module tb_dns_message_parser;
  import dmp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAD = 8;
  localparam logic [APB_ADDR_W-1:0] NAME_LIMIT_ADDR = APB_ADDR_W'(4 * REG_NAME_LIMIT);

  typedef enum logic [3:0] {
    PH_HDR, PH_NAME, PH_QTYPE, PH_QCLASS, PH_TYPE, PH_CLASS,
    PH_TTL, PH_RDLEN, PH_RDATA, PH_DONE, PH_STOP
  } parse_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_ready;
  msg_beat_t msg = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_beat_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // parser model state
  logic [7:0] name_limit_cfg;
  parse_phase_e phase;
  int byte_idx;
  logic [31:0] accum;
  logic [15:0] sec_count [4];
  logic [1:0] cur_sect;
  logic [15:0] recs_left;
  int name_count;
  logic [15:0] rdata_left;
  logic [1:0] msg_status;

  res_beat_t expected_results[$];
  logic [7:0] msg_buf[$];
  int fail_cnt = 0;
  int send_idle_pct = 0;
  int ready_stall_pct = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int cycle_cnt = 0;

  dns_message_parser i_dut (
    .clk(clk), .rst(rst),
    .msg_valid(msg_valid), .msg_ready(msg_ready), .msg(msg),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_dns_message_parser: FAIL");
    $finish;
  end

  function automatic void clear_parse();
    phase = PH_HDR;
    byte_idx = 0;
    accum = '0;
    foreach (sec_count[i]) sec_count[i] = '0;
    cur_sect = '0;
    recs_left = '0;
    name_count = 0;
    rdata_left = '0;
    msg_status = STATUS_OK;
  endfunction

  function automatic void enter_section(int s);
    while (s < 4) begin
      if (sec_count[s] != 0) begin
        cur_sect = s[1:0];
        recs_left = sec_count[s];
        name_count = 0;
        phase = PH_NAME;
        return;
      end
      s++;
    end
    phase = PH_DONE;
  endfunction

  function automatic void finish_record();
    recs_left = recs_left - 16'd1;
    if (recs_left == 0) begin
      enter_section(int'(cur_sect) + 1);
    end else begin
      name_count = 0;
      phase = PH_NAME;
    end
  endfunction

  function automatic void predict_beat(input logic [7:0] b, input logic is_last);
    res_beat_t r;
    logic have;
    parse_phase_e ph;
    int idx, pos, lim, width, c;
    have = 1'b0;
    ph = phase;
    r.field_kind = KIND_END_ONLY;
    r.field_value = '0;
    r.section = cur_sect;
    case (ph)
      PH_HDR: begin
        idx = byte_idx;
        accum = {accum[23:0], b};
        byte_idx = idx + 1;
        r.section = '0;
        if (idx == 1) begin
          have = 1'b1;
          r.field_kind = KIND_ID;
          r.field_value = {16'd0, accum[15:0]};
        end else if (idx == 2 || idx == 3) begin
          have = 1'b1;
          r.field_kind = (idx == 2) ? KIND_FLAGS1 : KIND_FLAGS2;
          r.field_value = {24'd0, b};
        end else if (idx >= 5 && idx <= 11 && idx[0]) begin
          c = (idx - 5) / 2;
          have = 1'b1;
          r.field_kind = KIND_QDCOUNT + 5'(c);
          r.field_value = {16'd0, accum[15:0]};
          sec_count[c] = accum[15:0];
          if (idx == 11) begin
            byte_idx = 0;
            accum = '0;
            cur_sect = '0;
            enter_section(0);
          end
        end
      end
      PH_NAME: begin
        lim = (name_limit_cfg > MAX_NAME_LEN) ? int'(MAX_NAME_LEN) : int'(name_limit_cfg);
        pos = name_count + 1;
        if (pos > lim) begin
          msg_status = STATUS_NAME_LONG;
          phase = PH_STOP;
        end else if (b == 8'd0) begin
          have = 1'b1;
          r.field_kind = KIND_NAME_END;
          r.field_value = pos;
          name_count = 0;
          phase = (cur_sect == 0) ? PH_QTYPE : PH_TYPE;
        end else begin
          have = 1'b1;
          r.field_kind = KIND_NAME_BYTE;
          r.field_value = {24'd0, b};
          name_count = pos;
        end
      end
      PH_QTYPE, PH_QCLASS, PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN: begin
        width = (ph == PH_TTL) ? 4 : 2;
        accum = {accum[23:0], b};
        byte_idx++;
        if (byte_idx >= width) begin
          r.field_value = accum;
          byte_idx = 0;
          accum = '0;
          have = 1'b1;
          case (ph)
            PH_QTYPE: begin
              r.field_kind = KIND_QTYPE;
              phase = PH_QCLASS;
            end
            PH_QCLASS: begin
              r.field_kind = KIND_QCLASS;
              finish_record();
            end
            PH_TYPE: begin
              r.field_kind = KIND_TYPE;
              phase = PH_CLASS;
            end
            PH_CLASS: begin
              r.field_kind = KIND_CLASS;
              phase = PH_TTL;
            end
            PH_TTL: begin
              r.field_kind = KIND_TTL;
              phase = PH_RDLEN;
            end
            default: begin
              r.field_kind = KIND_RDLENGTH;
              rdata_left = r.field_value[15:0];
              if (rdata_left == 0) finish_record();
              else phase = PH_RDATA;
            end
          endcase
        end
      end
      PH_RDATA: begin
        have = 1'b1;
        r.field_kind = KIND_RDATA_BYTE;
        r.field_value = {24'd0, b};
        rdata_left = rdata_left - 16'd1;
        if (rdata_left == 0) finish_record();
      end
      default: ;
    endcase
    if (is_last) begin
      if (phase != PH_DONE && msg_status == STATUS_OK)
        msg_status = (phase == PH_HDR) ? STATUS_SHORT : STATUS_TRUNC;
      if (!have) begin
        r.field_kind = KIND_END_ONLY;
        r.field_value = '0;
      end
      r.status = msg_status;
      r.end_of_message = 1'b1;
      expected_results.push_back(r);
      clear_parse();
    end else if (have) begin
      r.status = msg_status;
      r.end_of_message = 1'b0;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("res.%s: expected 0x%0h, got 0x%0h", fname, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    res_beat_t want;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: kind %0d value 0x%0h",
                 res.field_kind, res.field_value);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("field_kind", 32'(want.field_kind), 32'(res.field_kind));
          check_field("section", 32'(want.section), 32'(res.section));
          check_field("field_value", want.field_value, res.field_value);
          check_field("status", 32'(want.status), 32'(res.status));
          check_field("end_of_message", 32'(want.end_of_message),
                      32'(res.end_of_message));
        end
      end
      if (msg_valid && msg_ready) predict_beat(msg.data_byte, msg.last_byte);
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      msg_valid <= 1'b0;
    end
    @(negedge clk);
    msg_valid <= 1'b1;
    msg <= '{data_byte: b, last_byte: is_last};
    do @(posedge clk); while (!msg_ready);
  endtask

  task automatic send_message();
    foreach (msg_buf[i]) send_beat(msg_buf[i], i == msg_buf.size() - 1);
    msg_buf.delete();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    msg_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_name_limit(input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= NAME_LIMIT_ADDR;
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    name_limit_cfg = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) begin
      $error("prdata name_limit: expected 0x%0h, got 0x%0h", value, prdata[7:0]);
      fail_cnt++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void put16(input logic [15:0] v);
    msg_buf.push_back(v[15:8]);
    msg_buf.push_back(v[7:0]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  // name of nlen bytes counting the terminating zero
  function automatic void put_name(input int nlen);
    repeat (nlen - 1) msg_buf.push_back(8'($urandom_range(1, 255)));
    msg_buf.push_back(8'd0);
  endfunction

  function automatic void put_header(input logic [15:0] id, input logic [7:0] f1,
                                     input logic [7:0] f2, input logic [15:0] qd,
                                     input logic [15:0] an, input logic [15:0] ns,
                                     input logic [15:0] ar);
    put16(id);
    msg_buf.push_back(f1);
    msg_buf.push_back(f2);
    put16(qd);
    put16(an);
    put16(ns);
    put16(ar);
  endfunction

  function automatic void put_question(input int nlen, input logic [15:0] qtype,
                                       input logic [15:0] qclass);
    put_name(nlen);
    put16(qtype);
    put16(qclass);
  endfunction

  function automatic void put_record(input int nlen, input logic [15:0] rtype,
                                     input logic [15:0] rclass, input logic [31:0] ttl,
                                     input int rdlen);
    put_name(nlen);
    put16(rtype);
    put16(rclass);
    put32(ttl);
    put16(16'(rdlen));
    repeat (rdlen) msg_buf.push_back(8'($urandom));
  endfunction

  function automatic void build_random_message();
    int pick, cut;
    logic [15:0] cnt [4];
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 30)) msg_buf.push_back(8'($urandom));
      return;
    end
    foreach (cnt[i]) cnt[i] = 16'($urandom_range(0, 1));
    if ($urandom_range(19) == 0) cnt[$urandom_range(3)] = 16'($urandom);
    put_header(16'($urandom), 8'($urandom), 8'($urandom), cnt[0], cnt[1], cnt[2], cnt[3]);
    for (int q = 0; q < cnt[0] && q < 3; q++)
      put_question($urandom_range(1, 10), 16'($urandom), 16'($urandom));
    for (int s = 1; s < 4; s++)
      for (int r = 0; r < cnt[s] && r < 3; r++)
        put_record($urandom_range(1, 10), 16'($urandom), 16'($urandom), $urandom,
                   $urandom_range(0, 6));
    if (pick < 25) begin
      cut = $urandom_range(1, msg_buf.size());
      while (msg_buf.size() > cut) void'(msg_buf.pop_back());
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 4)) msg_buf.push_back(8'($urandom));
    end
  endfunction

  task automatic test_short_message();
    msg_buf.push_back(8'hFF);
    send_message();
    msg_buf = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF};
    send_message();
  endtask

  task automatic test_header_only();
    put_header(16'hFFFF, 8'hFF, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0);
    send_message();
    put_header(16'h0000, 8'h00, 8'hFF, 16'd0, 16'd0, 16'd0, 16'd0);
    msg_buf.push_back(8'hFF);
    msg_buf.push_back(8'h00);
    send_message();
  endtask

  task automatic test_question();
    put_header(16'h1234, 8'h81, 8'h80, 16'd1, 16'd0, 16'd0, 16'd0);
    msg_buf.push_back(8'h01);
    msg_buf.push_back(8'hFF);
    msg_buf.push_back(8'h00);
    put16(16'hFFFF);
    put16(16'h0001);
    send_message();
  endtask

  task automatic test_records();
    put_header(16'h0001, 8'h00, 8'h00, 16'd0, 16'd1, 16'd1, 16'd1);
    msg_buf.push_back(8'h00);
    put16(16'h0001);
    put16(16'hFFFF);
    put32(32'hFFFF_FFFF);
    put16(16'd2);
    msg_buf.push_back(8'hFF);
    msg_buf.push_back(8'h00);
    put_record(2, 16'h0000, 16'h0000, 32'h0000_0000, 0);
    put_record(1, 16'h0005, 16'h0001, 32'h8000_0001, 1);
    send_message();
  endtask

  task automatic test_truncated();
    put_header(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    msg_buf.push_back(8'h41);
    msg_buf.push_back(8'h42);
    send_message();
    put_header(16'h0002, 8'h00, 8'h00, 16'd0, 16'd1, 16'd0, 16'd0);
    msg_buf.push_back(8'h00);
    put16(16'h0001);
    put16(16'h0001);
    put32(32'd300);
    put16(16'hFFFF);
    repeat (3) msg_buf.push_back(8'($urandom));
    send_message();
  endtask

  task automatic test_name_limits();
    wait_idle();
    write_name_limit(8'd1);
    put_header(16'h0003, 8'h00, 8'h00, 16'd1, 16'd0, 16'd0, 16'd0);
    put_question(1, 16'd1, 16'd1);
    send_message();
    put_header(16'h0004, 8'h00, 8'h00, 16'd1, 16'd0, 16'd0, 16'd0);
    put_question(2, 16'd1, 16'd1);
    send_message();
    wait_idle();
    write_name_limit(8'd0);
    put_header(16'h0005, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 16'd1);
    put_record(1, 16'd1, 16'd1, 32'd1, 1);
    send_message();
    wait_idle();
    write_name_limit(8'd255);
    put_header(16'h0007, 8'h00, 8'h00, 16'd1, 16'd0, 16'd0, 16'd0);
    put_question(256, 16'd1, 16'd1);
    send_message();
    wait_idle();
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0;
    ready_stall_pct = 0;
    hold_req = 300;
    put_header(16'h0008, 8'h00, 8'h00, 16'd0, 16'd3, 16'd0, 16'd0);
    repeat (3) put_record(5, 16'($urandom), 16'($urandom), $urandom, 8);
    send_message();
    wait_idle();
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input logic [7:0] limit, input int budget);
    int sent;
    sent = 0;
    wait_idle();
    write_name_limit(limit);
    send_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    while (sent < budget) begin
      build_random_message();
      sent += msg_buf.size();
      send_message();
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 8'd255, 30);
    run_random_phase(46, 0, 8'($urandom_range(2, 254)), 30);
    run_random_phase(0, 46, 8'd6, 30);
    run_random_phase(16, 16, 8'd8, 30);
    run_random_phase(0, 0, 8'd1, 15);
  endtask

  initial begin
    name_limit_cfg = NAME_LIMIT_RESET;
    clear_parse();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_short_message();
    test_header_only();
    test_question();
    test_records();
    test_truncated();
    test_name_limits();
    test_back_pressure();
    test_random_traffic();
    wait_idle();
    if (fail_cnt == 0) begin
      $display("tb_dns_message_parser: PASS");
    end else begin
      $display("tb_dns_message_parser: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dmp_pkg.sv
hw/rtl/dmp_apb_regs.sv
hw/rtl/dmp_in_reg.sv
hw/rtl/dmp_parse_core.sv
hw/rtl/dmp_out_reg.sv
hw/rtl/dns_message_parser.sv
hw/rtl/dmp_checker.sv
verif/tb_dns_message_parser.sv
